### rtl/bitmap_page_allocator_macros.svh
// Assertion macros for the bitmap page allocator checker
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// clocked check, off during reset
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check, also live during reset
`define BPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/bpa_pkg.sv
// Types, codes and helper functions shared by the bitmap page allocator
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int CNT_W          = 13;
  localparam int ALLOC_W        = 24;
  localparam int PADDR_W        = 32;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int RESERVED_BYTES = 2 * 1024 * 1024;
  localparam int PAGE_TOTAL_RST = 4096;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;
  localparam logic [1:0] MODE_STATS = 2'd3;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NO_PAGE = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED   = 2'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [PADDR_W-1:0] page_address;
  } in_beat_t;

  typedef struct packed {
    logic [ALLOC_W-1:0] alloc_address;
    logic [1:0]         status;
    logic [CNT_W-1:0]   total_count;
    logic [CNT_W-1:0]   free_count_out;
    logic [CNT_W-1:0]   used_count;
  } out_beat_t;

  // bits of map word w that hold pages below lim
  function automatic logic [WORD_BITS-1:0] word_mask(logic [31:0] w, logic [CNT_W-1:0] lim);
    logic [31:0] full;
    logic [WORD_BITS-1:0] m;
    full = 32'(lim >> BIT_W);
    if (w < full) begin
      m = '1;
    end else if (w == full) begin
      m = (WORD_BITS'(1) << lim[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_set(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### rtl/bpa_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bpa_pgdiv.sv
// Byte address to page index conversion, a registered shift by the page size
`timescale 1ns / 1ps

module bpa_pgdiv #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bpa_pkg::PADDR_W-1:0] dividend,
  output logic                        done,
  output logic [bpa_pkg::CNT_W-1:0]   page
);

  localparam int PG_SHIFT = $clog2(PAGE_BYTES);

  // dividend is below active_total * PAGE_BYTES, so the quotient fits CNT_W bits
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      page <= bpa_pkg::CNT_W'(dividend >> PG_SHIFT);
    end
  end

endmodule

### rtl/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per page in a 64-bit-wide map RAM
// Allocate: scans the map words in order (up to 64 at 4096 pages) and takes the lowest free page.
// Free: address shift, RAM read, write back; stats: goes straight to the result.
// Init: one map word written per cycle, all DEPTH words; one item in flight at a time.
// After rst the map is swept with in_ready low; config writes are taken meanwhile.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int MAX_PAGES  = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpa_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpa_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_data
);

  localparam int WB        = bpa_pkg::WORD_BITS;
  localparam int CW        = bpa_pkg::CNT_W;
  localparam int BW        = bpa_pkg::BIT_W;
  localparam int WORDS_RAW = (MAX_PAGES + WB - 1) / WB;
  localparam int DEPTH     = (WORDS_RAW < 2) ? 2 : WORDS_RAW;
  localparam int AW        = $clog2(DEPTH);
  localparam int LIM_W     = CW + $clog2(PAGE_BYTES + 1);
  localparam int RES_RST   = bpa_pkg::RESERVED_BYTES / PAGE_BYTES;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_SETUP, S_INIT_SWEEP, S_SCAN, S_ALLOC_WR,
    S_DIV, S_FREE_RD, S_FREE_CHK, S_FIN
  } state_t;

  state_t            state;
  logic [CW-1:0]     page_total;
  logic [CW-1:0]     reserved_count;
  logic [CW-1:0]     active_total;
  logic [CW-1:0]     res_pages;
  logic [CW-1:0]     free_pages_left;
  logic [LIM_W-1:0]  limit;
  logic [AW-1:0]     last_word;
  logic [AW-1:0]     sweep_idx;
  logic [AW-1:0]     scan_idx;
  logic [AW-1:0]     rd_word;
  logic              rd_valid;
  logic [AW-1:0]     hit_word;
  logic [BW-1:0]     hit_bit;
  logic [WB-1:0]     hit_data;
  logic [CW-1:0]     free_page;
  logic              init_report;
  logic [1:0]        res_status;
  logic [CW-1:0]     res_page;

  logic [CW-1:0]     tot_clamp;
  logic [CW-1:0]     res_clamp;
  logic [WB-1:0]     avail;
  logic [AW-1:0]     free_word;
  logic              free_hit;
  logic              addr_in_range;
  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_page;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WB-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WB-1:0]     ram_rdata;

  assign in_ready      = (state == S_IDLE);
  assign tot_clamp     = (32'(page_total) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : page_total;
  assign res_clamp     = (reserved_count > tot_clamp) ? tot_clamp : reserved_count;
  assign avail         = ~ram_rdata & bpa_pkg::word_mask(32'(rd_word), active_total);
  assign free_word     = AW'(free_page >> BW);
  assign free_hit      = ram_rdata[free_page[BW-1:0]];
  assign addr_in_range = in_data.page_address < 32'(limit);
  assign div_start     = in_valid && in_ready && (in_data.mode == bpa_pkg::MODE_FREE)
                         && addr_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_total     <= CW'(bpa_pkg::PAGE_TOTAL_RST);
      reserved_count <= CW'(RES_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        bpa_pkg::REG_PAGE_TOTAL: page_total     <= cfg_data;
        bpa_pkg::REG_RESERVED:   reserved_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_idx;
    ram_wdata = bpa_pkg::word_mask(32'(sweep_idx), res_pages);
    ram_re    = 1'b0;
    ram_raddr = scan_idx;
    case (state)
      S_INIT_SWEEP: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_re = 1'b1;
      end
      S_ALLOC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_word;
        ram_wdata = hit_data | (WB'(1) << hit_bit);
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = free_word;
      end
      S_FREE_CHK: begin
        ram_we    = free_hit;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~(WB'(1) << free_page[BW-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT_SETUP;
      init_report <= 1'b0;
      out_valid   <= 1'b0;
      rd_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          res_page   <= '0;
          res_status <= bpa_pkg::STAT_DONE;
          if (in_valid) begin
            case (in_data.mode)
              bpa_pkg::MODE_ALLOC: begin
                if (free_pages_left == '0) begin
                  res_status <= bpa_pkg::STAT_NO_PAGE;
                  state      <= S_FIN;
                end else begin
                  scan_idx <= '0;
                  rd_valid <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              bpa_pkg::MODE_FREE: begin
                if (addr_in_range) begin
                  state <= S_DIV;
                end else begin
                  res_status <= bpa_pkg::STAT_IGNORED;
                  state      <= S_FIN;
                end
              end
              bpa_pkg::MODE_INIT: begin
                init_report <= 1'b1;
                state       <= S_INIT_SETUP;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_INIT_SETUP: begin
          active_total    <= tot_clamp;
          res_pages       <= res_clamp;
          free_pages_left <= tot_clamp - res_clamp;
          last_word       <= AW'((tot_clamp - CW'(1)) >> BW);
          sweep_idx       <= '0;
          state           <= S_INIT_SWEEP;
        end
        S_INIT_SWEEP: begin
          limit     <= LIM_W'(32'(active_total) * 32'(PAGE_BYTES));
          sweep_idx <= sweep_idx + AW'(1);
          if (sweep_idx == AW'(DEPTH - 1)) begin
            state <= init_report ? S_FIN : S_IDLE;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + AW'(1);
          rd_word  <= scan_idx;
          rd_valid <= 1'b1;
          if (rd_valid) begin
            if (avail != '0) begin
              hit_word <= rd_word;
              hit_bit  <= bpa_pkg::lowest_set(avail);
              hit_data <= ram_rdata;
              state    <= S_ALLOC_WR;
            end else if (rd_word == last_word) begin
              res_status <= bpa_pkg::STAT_NO_PAGE;
              state      <= S_FIN;
            end
          end
        end
        S_ALLOC_WR: begin
          free_pages_left <= free_pages_left - CW'(1);
          res_page        <= CW'({hit_word, hit_bit});
          state           <= S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            free_page <= div_page;
            state     <= S_FREE_RD;
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (free_hit) begin
            if (free_pages_left < active_total) begin
              free_pages_left <= free_pages_left + CW'(1);
            end
          end else begin
            res_status <= bpa_pkg::STAT_IGNORED;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.alloc_address   <= bpa_pkg::ALLOC_W'(32'(res_page) * 32'(PAGE_BYTES));
            out_data.status          <= res_status;
            out_data.total_count     <= active_total;
            out_data.free_count_out  <= free_pages_left;
            out_data.used_count      <= active_total - free_pages_left;
            init_report              <= 1'b0;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_pgdiv #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_data.page_address),
    .done     (div_done),
    .page     (div_page)
  );

endmodule

### rtl/bpa_checker.sv
// Port-level assertions for the bitmap page allocator, bound to the top level
`timescale 1ns / 1ps
`include "bitmap_page_allocator_macros.svh"

module bpa_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bpa_pkg::out_beat_t out_data
);

  logic [bpa_pkg::CNT_W-1:0] count_sum;
  logic                      out_stall;
  logic                      in_fire;
  logic                      counts_ok;
  logic                      no_page;
  logic                      no_page_ok;

  assign count_sum  = out_data.used_count + out_data.free_count_out;
  assign out_stall  = out_valid && !out_ready;
  assign in_fire    = in_valid && in_ready;
  assign counts_ok  = (count_sum == out_data.total_count)
                      && (out_data.free_count_out <= out_data.total_count);
  assign no_page    = out_valid && (out_data.status == bpa_pkg::STAT_NO_PAGE);
  assign no_page_ok = (out_data.alloc_address == '0) && (out_data.free_count_out == '0);

  `BPA_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "result beat not held")
  `BPA_ASSERT(a_counts, out_valid |-> counts_ok, "page counts inconsistent")
  `BPA_ASSERT(a_no_page, no_page |-> no_page_ok, "no-page result with address or free pages")
  `BPA_ASSERT(a_one_item, in_fire |=> !in_ready, "second item taken while one is in flight")
  `BPA_ASSERT_ALWAYS(a_reset_busy, rst |=> !in_ready && !out_valid, "busy after reset")

endmodule

bind bitmap_page_allocator bpa_port_checker u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
